// ===== hw/rtl/hfd_pkg.sv =====
// hfd_pkg: types and fixed constants of the half flux diameter block
// field widths, register indexes, reset values and the sequencer states
// no dependencies
package hfd_pkg;

    localparam int PIXEL_W    = 24;
    localparam int GRAY_W     = 8;
    localparam int CFG_SIZE_W = 13;
    localparam int CFG_DIAM_W = 10;
    localparam int CFG_BG_W   = 8;
    localparam int CFG_DATA_W = 13;
    localparam int RADIUS_W   = 9;
    localparam int RSQ_W      = 18;
    localparam int FLUX_W     = 32;
    localparam int WSUM_W     = 48;
    localparam int HFD_W      = 18;

    localparam logic [HFD_W-1:0] HFD_MAX = '1;

    localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET  = 13'd64;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET = 13'd64;
    localparam logic [CFG_DIAM_W-1:0] DIAM_RESET   = 10'd60;
    localparam logic [CFG_BG_W-1:0]   BG_RESET     = 8'd0;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_OUTER_DIAM,
        CFG_BACKGROUND
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_CHK,
        S_ROOT,
        S_MUL,
        S_POST,
        S_DIV,
        S_OUT
    } hfd_state_t;

endpackage

// ===== hw/rtl/half_flux_diameter_top.sv =====
// half flux diameter focus metric over a raster frame of packed rgb pixels
// two-bit-per-cycle square root, shift-add multiplier, bit-serial divider
// depends on hfd_pkg
// a pixel outside the aperture, dark or at the centre passes S_SQR, S_CHK and S_POST before the next accept
// a lit pixel inside also passes the square root unit in S_ROOT and the multiplier in S_MUL before S_POST:
// the root runs over DIST_FRAC_BITS + 10 root bits, the multiplier up to the top set bit of its gray level
// after the last pixel the square root (no flux) or the divider runs before out_valid, unless the quotient overflows
// asynchronous active-low reset clears position, sums and pending result, restores register defaults
module half_flux_diameter_top #(
    parameter int COORD_BITS     = 12,
    parameter int DIST_FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [hfd_pkg::PIXEL_W-1:0]      pixel_rgb,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hfd_pkg::HFD_W-1:0]        hfd_q8,
    output logic                             no_flux,
    input  logic                             cfg_write,
    input  hfd_pkg::cfg_index_t              cfg_index,
    input  logic [hfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hfd_pkg::*;

    localparam int SZ_W      = (COORD_BITS + 1 > CFG_SIZE_W) ? COORD_BITS + 1 : CFG_SIZE_W;
    localparam int D2_W      = 2 * COORD_BITS + 1;
    localparam int SQ_W      = 2 * COORD_BITS + 2;
    localparam int CMP_W     = (D2_W > RSQ_W) ? D2_W : RSQ_W;
    localparam int NRES      = DIST_FRAC_BITS + 10;
    localparam int ROOT_IN_W = 2 * NRES;
    localparam int REM_W     = NRES + 3;
    localparam int SAT_W     = NRES + HFD_W;
    localparam int ITER_MAX  = (NRES > HFD_W) ? NRES : HFD_W;
    localparam int CNT_W     = $clog2(ITER_MAX);

    hfd_state_t state_reg, state_next;

    logic [CFG_SIZE_W-1:0]      img_w_reg, img_h_reg;
    logic [CFG_DIAM_W-1:0]      diam_reg;
    logic [CFG_BG_W-1:0]        bg_reg;

    logic [COORD_BITS-1:0]      col_reg, col_next;
    logic [COORD_BITS-1:0]      row_reg, row_next;
    logic [FLUX_W-1:0]          flux_reg, flux_next;
    logic [WSUM_W-1:0]          wsum_reg, wsum_next;
    logic                       out_valid_reg, out_valid_next;

    logic [HFD_W-1:0]           out_hfd_reg, out_hfd_next;
    logic                       out_none_reg, out_none_next;
    logic                       last_reg, last_next;
    logic [GRAY_W-1:0]          gray_reg, gray_next;
    logic signed [COORD_BITS:0] dx_reg, dx_next;
    logic signed [COORD_BITS:0] dy_reg, dy_next;
    logic [D2_W-1:0]            d2_reg, d2_next;
    logic [ROOT_IN_W-1:0]       rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [NRES-1:0]            root_reg, root_next;
    logic                       final_root_reg, final_root_next;
    logic [WSUM_W-1:0]          mcand_reg, mcand_next;
    logic [GRAY_W-1:0]          gsh_reg, gsh_next;
    logic [FLUX_W-1:0]          div_rem_reg, div_rem_next;
    logic [HFD_W-1:0]           div_low_reg, div_low_next;
    logic [HFD_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [HFD_W-1:0]           res_hfd_reg, res_hfd_next;
    logic                       res_none_reg, res_none_next;

    logic [SZ_W-1:0]            w_use, h_use, cx, cy;
    logic                       row_end, last_pix, accept;
    logic [12:0]                luma_sum;
    logic [GRAY_W-1:0]          gray_raw, gray_val;
    logic [RADIUS_W-1:0]        radius;
    logic [RSQ_W-1:0]           rsq;
    logic [CMP_W-1:0]           d2_cmp;
    logic                       in_aperture;
    logic signed [SQ_W-1:0]     dx_sq, dy_sq, d2_sum;
    logic [REM_W-1:0]           root_t, root_trial;
    logic                       root_ge;
    logic [NRES-1:0]            root_q;
    logic [SAT_W-1:0]           root_wide;
    logic [HFD_W-1:0]           root_sat;
    logic [FLUX_W:0]            div_t, div_d;
    logic                       div_ge;
    logic [FLUX_W-1:0]          div_r;
    logic [WSUM_W-1:0]          wsum_add;

    function automatic logic [SZ_W-1:0] usable_size(input logic [CFG_SIZE_W-1:0] v);
        logic [SZ_W-1:0] ext;
        logic [SZ_W-1:0] lim;
        ext = SZ_W'(v);
        lim = SZ_W'(1) << COORD_BITS;
        if (ext == '0)
        begin
            usable_size = SZ_W'(1);
        end
        else if (ext > lim)
        begin
            usable_size = lim;
        end
        else
        begin
            usable_size = ext;
        end
    endfunction

    assign w_use    = usable_size(img_w_reg);
    assign h_use    = usable_size(img_h_reg);
    assign cx       = (w_use + SZ_W'(1)) >> 1;
    assign cy       = (h_use + SZ_W'(1)) >> 1;
    assign row_end  = SZ_W'(col_reg) >= (w_use - SZ_W'(1));
    assign last_pix = row_end && (SZ_W'(row_reg) >= (h_use - SZ_W'(1)));
    assign accept   = in_valid && in_ready;

    assign luma_sum = 13'(pixel_rgb[23:16]) * 13'd11 + {1'b0, pixel_rgb[15:8], 4'b0000}
                    + 13'(pixel_rgb[7:0]) * 13'd5;
    assign gray_raw = luma_sum[12:5];
    assign gray_val = (gray_raw > bg_reg) ? gray_raw - bg_reg : '0;

    assign radius      = diam_reg[CFG_DIAM_W-1:1];
    assign rsq         = RSQ_W'(radius) * RSQ_W'(radius);
    assign d2_cmp      = CMP_W'(d2_reg);
    assign in_aperture = d2_cmp <= CMP_W'(rsq);

    assign dx_sq  = dx_reg * dx_reg;
    assign dy_sq  = dy_reg * dy_reg;
    assign d2_sum = dx_sq + dy_sq;

    // one root bit per cycle from two radicand bits
    assign root_t     = {rem_reg[REM_W-3:0], rad_reg[ROOT_IN_W-1 -: 2]};
    assign root_trial = REM_W'({root_reg, 2'b01});
    assign root_ge    = root_t >= root_trial;
    assign root_q     = {root_reg[NRES-2:0], root_ge};
    assign root_wide  = SAT_W'(root_q);
    assign root_sat   = (root_wide > SAT_W'(HFD_MAX)) ? HFD_MAX : root_wide[HFD_W-1:0];

    // one quotient bit per cycle
    assign div_t  = {div_rem_reg, div_low_reg[HFD_W-1]};
    assign div_d  = {1'b0, flux_reg};
    assign div_ge = div_t >= div_d;
    assign div_r  = FLUX_W'(div_t - div_d);

    assign wsum_add = wsum_reg + mcand_reg;

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        flux_next       = flux_reg;
        wsum_next       = wsum_reg;
        out_valid_next  = out_valid_reg;
        out_hfd_next    = out_hfd_reg;
        out_none_next   = out_none_reg;
        last_next       = last_reg;
        gray_next       = gray_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        d2_next         = d2_reg;
        rad_next        = rad_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        final_root_next = final_root_reg;
        mcand_next      = mcand_reg;
        gsh_next        = gsh_reg;
        div_rem_next    = div_rem_reg;
        div_low_next    = div_low_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        res_hfd_next    = res_hfd_reg;
        res_none_next   = res_none_reg;
        in_ready        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    gray_next = gray_val;
                    last_next = last_pix;
                    dx_next   = $signed({1'b0, col_reg}) - $signed({1'b0, cx[COORD_BITS-1:0]});
                    dy_next   = $signed({1'b0, row_reg}) - $signed({1'b0, cy[COORD_BITS-1:0]});
                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = last_pix ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                d2_next    = d2_sum[D2_W-1:0];
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_POST;
                if (in_aperture)
                begin
                    flux_next = flux_reg + FLUX_W'(gray_reg);
                    if (gray_reg != '0 && d2_reg != '0)
                    begin
                        rad_next        = ROOT_IN_W'(d2_cmp[RSQ_W-1:0]) << (2 * DIST_FRAC_BITS);
                        rem_next        = '0;
                        root_next       = '0;
                        cnt_next        = '0;
                        final_root_next = 1'b0;
                        state_next      = S_ROOT;
                    end
                end
            end
            S_ROOT:
            begin
                rem_next  = root_ge ? root_t - root_trial : root_t;
                root_next = root_q;
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NRES - 1))
                begin
                    if (final_root_reg)
                    begin
                        res_hfd_next  = root_sat;
                        res_none_next = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        mcand_next = WSUM_W'(root_q);
                        gsh_next   = gray_reg;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (gsh_reg[0])
                begin
                    wsum_next = wsum_add;
                end
                mcand_next = mcand_reg << 1;
                gsh_next   = gsh_reg >> 1;
                if (gsh_reg[GRAY_W-1:1] == '0)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (flux_reg == '0)
                begin
                    rad_next        = ROOT_IN_W'({rsq, 1'b0}) << (2 * DIST_FRAC_BITS);
                    rem_next        = '0;
                    root_next       = '0;
                    cnt_next        = '0;
                    final_root_next = 1'b1;
                    state_next      = S_ROOT;
                end
                else if (FLUX_W'(wsum_reg[WSUM_W-1:HFD_W-1]) >= flux_reg)
                begin
                    // quotient would not fit the result field
                    res_hfd_next  = HFD_MAX;
                    res_none_next = 1'b0;
                    state_next    = S_OUT;
                end
                else
                begin
                    div_rem_next = FLUX_W'(wsum_reg[WSUM_W-1:HFD_W-1]);
                    div_low_next = {wsum_reg[HFD_W-2:0], 1'b0};
                    quo_next     = '0;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                div_rem_next = div_ge ? div_r : div_t[FLUX_W-1:0];
                div_low_next = div_low_reg << 1;
                quo_next     = {quo_reg[HFD_W-2:0], div_ge};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HFD_W - 1))
                begin
                    res_hfd_next  = {quo_reg[HFD_W-2:0], div_ge};
                    res_none_next = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hfd_next   = res_hfd_reg;
                    out_none_next  = res_none_reg;
                    flux_next      = '0;
                    wsum_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (!accept && state_reg == S_IDLE)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg     <= WIDTH_RESET;
            img_h_reg     <= HEIGHT_RESET;
            diam_reg      <= DIAM_RESET;
            bg_reg        <= BG_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            flux_reg      <= '0;
            wsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            flux_reg      <= flux_next;
            wsum_reg      <= wsum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                    CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                    CFG_OUTER_DIAM:   diam_reg  <= cfg_data[CFG_DIAM_W-1:0];
                    CFG_BACKGROUND:   bg_reg    <= cfg_data[CFG_BG_W-1:0];
                    default:          bg_reg    <= bg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_hfd_reg    <= out_hfd_next;
        out_none_reg   <= out_none_next;
        last_reg       <= last_next;
        gray_reg       <= gray_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        d2_reg         <= d2_next;
        rad_reg        <= rad_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        final_root_reg <= final_root_next;
        mcand_reg      <= mcand_next;
        gsh_reg        <= gsh_next;
        div_rem_reg    <= div_rem_next;
        div_low_reg    <= div_low_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        res_hfd_reg    <= res_hfd_next;
        res_none_reg   <= res_none_next;
    end

    assign out_valid = out_valid_reg;
    assign hfd_q8    = out_hfd_reg;
    assign no_flux   = out_none_reg;

endmodule

// ===== hw/rtl/hfd_checker.sv =====
// hfd_checker: port-level checks of the half flux diameter top level
// attached to half_flux_diameter_top by the bind at the end of this file
// depends on hfd_pkg
module hfd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [hfd_pkg::HFD_W-1:0]   hfd_q8,
    input logic                        no_flux
);
    import hfd_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hfd_q8) && $stable(no_flux))
    else $error("result beat changed while stalled");

    // in_ready stays low after a pixel beat while the block passes S_SQR, S_CHK and then S_POST or S_ROOT
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("pixel beat taken too early after previous one");

    // a result is produced only while no pixel can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while block was idle");

    // a result never appears in the cycle right after a pixel beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a pixel beat");

endmodule

bind half_flux_diameter_top hfd_checker u_hfd_checker (.*);

// ===== tb/half_flux_diameter_top_test.sv =====
`timescale 1ns / 100ps
// half_flux_diameter_top_test: self-checking bench for the half flux diameter block
// directed table, a short oversize stretch, then random frames at random sizes and stalls
// depends on hfd_pkg and half_flux_diameter_top
module half_flux_diameter_top_test;

    import hfd_pkg::*;

    localparam int COORD_BITS     = 12;
    localparam int DIST_FRAC_BITS = 8;
    localparam int RANDOM_PIXELS  = 900;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        logic [HFD_W-1:0] hfd;
        logic             no_flux;
    } hfd_result_t;

    typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_index_t            idx;
        logic [CFG_DATA_W-1:0] value;
        logic [PIXEL_W-1:0]    pixel;
        logic                  known;
        logic [HFD_W-1:0]      known_hfd;
        logic                  known_nf;
    } plan_row_t;

    localparam int PLAN_ROWS = 30;

    // pixels before the first write land at row 0 of the default 64x64 frame
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h123456, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_IMAGE_WIDTH,  13'd4,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 13'd1,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, 18'd724, 1'b0},
        '{ROW_REG, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_OUTER_DIAM,   13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_BACKGROUND,   13'd255,  24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, 18'd0,   1'b1},
        '{ROW_REG, CFG_OUTER_DIAM,   13'd2,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_BACKGROUND,   13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, 18'd362, 1'b1},
        '{ROW_REG, CFG_IMAGE_WIDTH,  13'd2,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 13'd2,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h000000, 1'b1, 18'd512, 1'b0},
        '{ROW_REG, CFG_BACKGROUND,   13'd255,  24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFF0000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h00FF00, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h0000FF, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b1, 18'd362, 1'b1},
        '{ROW_REG, CFG_BACKGROUND,   13'd100,  24'h000000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFF0000, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h00FF00, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'h0000FF, 1'b0, 18'd0,   1'b0},
        '{ROW_PIX, CFG_IMAGE_WIDTH,  13'd0,    24'hFFFFFF, 1'b0, 18'd0,   1'b0}
    };

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [PIXEL_W-1:0]    pixel_rgb = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [HFD_W-1:0]      hfd_q8;
    logic                  no_flux;
    logic                  cfg_write = 1'b0;
    cfg_index_t            cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of registers, position and sums
    logic [CFG_SIZE_W-1:0] reg_width;
    logic [CFG_SIZE_W-1:0] reg_height;
    logic [CFG_DIAM_W-1:0] reg_diam;
    logic [CFG_BG_W-1:0]   reg_bg;
    logic [COORD_BITS-1:0] pos_col;
    logic [COORD_BITS-1:0] pos_row;
    logic [FLUX_W-1:0]     acc_flux;
    logic [WSUM_W-1:0]     acc_wdist;

    hfd_result_t pending_hfd [$];
    hfd_result_t head;
    bit          steady = 1'b0;
    int          error_count = 0;
    int          pixels_sent = 0;
    int          frames_done = 0;
    int          reg_writes  = 0;
    int          rand_pixels = 0;

    half_flux_diameter_top #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_rgb (pixel_rgb),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hfd_q8    (hfd_q8),
        .no_flux   (no_flux),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("half_flux_diameter_top_test: errors");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic int fit_size(input logic [CFG_SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > (1 << COORD_BITS))
            return 1 << COORD_BITS;
        return int'(v);
    endfunction

    function automatic void clear_model();
        reg_width  = WIDTH_RESET;
        reg_height = HEIGHT_RESET;
        reg_diam   = DIAM_RESET;
        reg_bg     = BG_RESET;
        pos_col    = '0;
        pos_row    = '0;
        acc_flux   = '0;
        acc_wdist  = '0;
    endfunction

    // one pixel into the aperture sums; returns 1 with the frame result at the last pixel
    function automatic bit account_pixel(input logic [PIXEL_W-1:0] pix, output hfd_result_t res);
        int              gray;
        int              w;
        int              h;
        int              dx;
        int              dy;
        int unsigned     rad;
        longint unsigned d2;
        longint unsigned dist_q;
        longint unsigned num;
        longint unsigned hfd;
        bit              row_end;
        bit              last;
        res  = '0;
        gray = (11 * int'(pix[23:16]) + 16 * int'(pix[15:8]) + 5 * int'(pix[7:0])) >> 5;
        gray = (gray > int'(reg_bg)) ? gray - int'(reg_bg) : 0;
        w    = fit_size(reg_width);
        h    = fit_size(reg_height);
        dx   = int'(pos_col) - (w + 1) / 2;
        dy   = int'(pos_row) - (h + 1) / 2;
        d2   = dx * dx + dy * dy;
        rad  = 32'(reg_diam >> 1);
        if (d2 <= rad * rad)
        begin
            dist_q    = int_sqrt(d2 << (2 * DIST_FRAC_BITS));
            acc_flux  = acc_flux + FLUX_W'(gray);
            acc_wdist = acc_wdist + WSUM_W'(gray * dist_q);
        end
        row_end = int'(pos_col) >= w - 1;
        last    = row_end && int'(pos_row) >= h - 1;
        if (row_end)
        begin
            pos_col = '0;
            pos_row = last ? '0 : pos_row + 1'b1;
        end
        else
            pos_col = pos_col + 1'b1;
        if (!last)
            return 1'b0;
        if (acc_flux != 0)
        begin
            num = acc_wdist;
            hfd = (num << 1) / acc_flux;
        end
        else
        begin
            num         = rad;
            hfd         = int_sqrt((2 * num * num) << (2 * DIST_FRAC_BITS));
            res.no_flux = 1'b1;
        end
        if (hfd > HFD_MAX)
            hfd = HFD_MAX;
        res.hfd   = hfd[HFD_W-1:0];
        acc_flux  = '0;
        acc_wdist = '0;
        return 1'b1;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            3:       return {3{8'($urandom_range(0, 40))}};
            default: return PIXEL_W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width  = val;
            CFG_IMAGE_HEIGHT: reg_height = val;
            CFG_OUTER_DIAM:   reg_diam   = val[CFG_DIAM_W-1:0];
            CFG_BACKGROUND:   reg_bg     = val[CFG_BG_W-1:0];
            default:          ;
        endcase
        reg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit use_known,
                              input hfd_result_t known);
        hfd_result_t guess;
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pixel_rgb <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (account_pixel(pix, guess))
        begin
            pending_hfd.push_back(use_known ? known : guess);
            frames_done++;
        end
        pixels_sent++;
    endtask

    // stop sending, let every frame result come back and the block settle
    task automatic idle_block();
        in_valid <= 1'b0;
        while (pending_hfd.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hfd.size() == 0)
                report_mismatch("result beat with no frame pending, hfd_q8",
                                longint'(hfd_q8), 0);
            else
            begin
                head = pending_hfd.pop_front();
                if (hfd_q8 !== head.hfd)
                    report_mismatch("hfd_q8", longint'(hfd_q8), longint'(head.hfd));
                if (no_flux !== head.no_flux)
                    report_mismatch("no_flux", longint'(no_flux), longint'(head.no_flux));
            end
        end
        out_ready <= steady || ($urandom_range(0, 99) >= 13);
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] val;
        int                    count;
        clear_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_REG)
            begin
                idle_block();
                write_reg(PLAN[i].idx, PLAN[i].value);
            end
            else
                send_pixel(PLAN[i].pixel, PLAN[i].known, '{PLAN[i].known_hfd, PLAN[i].known_nf});
        end

        // oversize sizes and widest aperture for a short stretch, then small sizes cut in
        idle_block();
        write_reg(CFG_IMAGE_WIDTH, 13'd8191);
        write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
        write_reg(CFG_OUTER_DIAM, 13'd1023);
        write_reg(CFG_BACKGROUND, CFG_DATA_W'($urandom_range(0, 40)));
        repeat (40) send_pixel(pick_pixel(), 1'b0, '0);
        idle_block();
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        repeat (6) send_pixel(pick_pixel(), 1'b0, '0);

        while (rand_pixels < RANDOM_PIXELS)
        begin
            idle_block();
            steady <= (rand_pixels >= 300 && rand_pixels < 450);
            val = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                           : $urandom_range(0, 6));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_IMAGE_WIDTH, val);
            val = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                           : $urandom_range(0, 6));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_IMAGE_HEIGHT, val);
            val = CFG_DATA_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 16)
                                                          : $urandom_range(0, 1023));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_OUTER_DIAM, val);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: val = '0;
                5, 6, 7:       val = CFG_DATA_W'($urandom_range(0, 60));
                default:       val = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_BACKGROUND, val);
            // mostly whole frames; sometimes stop mid frame so the next sizes cut in
            if ($urandom_range(0, 4) == 0)
                count = int'($urandom_range(1, 30));
            else
                count = fit_size(reg_width) * fit_size(reg_height)
                      * int'($urandom_range(1, 3));
            repeat (count)
            begin
                send_pixel(pick_pixel(), 1'b0, '0);
                rand_pixels++;
            end
        end

        idle_block();
        $display("run covered %0d pixels, %0d frame results, %0d register writes",
                 pixels_sent, frames_done, reg_writes);
        if (error_count == 0)
            $display("half_flux_diameter_top_test: clean");
        else
            $display("half_flux_diameter_top_test: errors");
        $finish;
    end

endmodule
